[rtl/wrf_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the windowed register file.
// Used by the controller, datapath, top level and checker; no dependencies.
package wrf_pkg;

    localparam int WINDOWS_DEF  = 8;
    localparam int GLOBAL_REGS  = 8;
    localparam int IO_REGS      = 8;
    localparam int LOCAL_REGS   = 8;
    localparam int WIN_SPAN     = IO_REGS + LOCAL_REGS;
    localparam int WIN_SHIFT    = $clog2(WIN_SPAN);
    localparam int DATA_W       = 32;
    localparam int NUM_W        = 5;
    localparam int WP_W         = 5;
    localparam int S_TDATA_W    = 40;
    localparam int S_TUSER_W    = 2;
    localparam int M_TDATA_W    = 40;

    localparam logic [NUM_W-1:0] REG_ZERO = '0;

    typedef enum logic [1:0] {
        ACT_READ    = 2'd0,
        ACT_WRITE   = 2'd1,
        ACT_SAVE    = 2'd2,
        ACT_RESTORE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOAD
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic access;
        logic load;
    } ctrl_cmd_t;

endpackage

[rtl/wrf_ctrl.sv]
`timescale 1ns / 1ps
// Sequencing controller: capture, access, load of one transaction at a time.
// Depends on wrf_pkg; drives the datapath through ctrl_cmd_t.
module wrf_ctrl
    import wrf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    output ctrl_cmd_t cmd
);

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        slot_free;

    assign slot_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.access  = 1'b0;
        cmd.load    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_EXEC: begin
                cmd.access = 1'b1;
            end
            ST_LOAD: begin
                cmd.load = slot_free;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        priority if (cmd.load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

[rtl/wrf_datapath.sv]
`timescale 1ns / 1ps
// Datapath: captured transaction, window pointer, register store and result register.
// Depends on wrf_pkg; controlled by wrf_ctrl through ctrl_cmd_t.
module wrf_datapath
    import wrf_pkg::*;
#(
    parameter int WINDOWS = WINDOWS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  ctrl_cmd_t         cmd,
    input  action_t           action,
    input  logic [NUM_W-1:0]  reg_number,
    input  logic [DATA_W-1:0] write_data,
    output logic [DATA_W-1:0] read_data,
    output logic              window_trap,
    output logic [WP_W-1:0]   window_pointer
);

    localparam int DEPTH = GLOBAL_REGS + WINDOWS * WIN_SPAN;
    localparam int IDX_W = $clog2(DEPTH);
    localparam logic [WP_W-1:0] LAST_WIN = WP_W'(WINDOWS - 1);

    action_t           action_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [DATA_W-1:0] wdata_reg;
    logic [WP_W-1:0]   cw_reg, cw_next;
    logic              trap_reg, trap_next;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] mem_q_reg;
    logic [DATA_W-1:0] rd_out_reg;
    logic              trap_out_reg;
    logic [WP_W-1:0]   wp_out_reg;

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            action_reg <= action;
            num_reg    <= reg_number;
            wdata_reg  <= write_data;
        end
    end

    always_comb begin
        priority if (num_reg < NUM_W'(GLOBAL_REGS)) begin
            idx = IDX_W'(num_reg);
        end else if (cw_reg == LAST_WIN && num_reg >= NUM_W'(GLOBAL_REGS + WIN_SPAN)) begin
            idx = IDX_W'(num_reg) - IDX_W'(WIN_SPAN);
        end else begin
            idx = (IDX_W'(cw_reg) << WIN_SHIFT) + IDX_W'(num_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.access) begin
            if (action_reg == ACT_WRITE && num_reg != REG_ZERO) begin
                mem[idx] <= wdata_reg;
            end
            mem_q_reg <= mem[idx];
        end
    end

    always_comb begin
        cw_next   = cw_reg;
        trap_next = 1'b0;
        unique case (action_reg)
            ACT_SAVE: begin
                if (cw_reg >= LAST_WIN) begin
                    cw_next   = '0;
                    trap_next = 1'b1;
                end else begin
                    cw_next = cw_reg + WP_W'(1);
                end
            end
            ACT_RESTORE: begin
                if (cw_reg == '0 || cw_reg > LAST_WIN) begin
                    cw_next   = LAST_WIN;
                    trap_next = 1'b1;
                end else begin
                    cw_next = cw_reg - WP_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cw_reg <= '0;
        end else if (cmd.access) begin
            cw_reg <= cw_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.access) begin
            trap_reg <= trap_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rd_out_reg   <= (action_reg == ACT_READ && num_reg != REG_ZERO) ? mem_q_reg : '0;
            trap_out_reg <= trap_reg;
            wp_out_reg   <= cw_reg;
        end
    end

    assign read_data      = rd_out_reg;
    assign window_trap    = trap_out_reg;
    assign window_pointer = wp_out_reg;

endmodule

[rtl/windowed_register_file.sv]
`timescale 1ns / 1ps
// Top level of the windowed register file: stream ports, controller and datapath.
// Depends on wrf_pkg, wrf_ctrl and wrf_datapath.
//
// Windowed register file with 8 globals and 16 registers per window (WINDOWS windows,
// ins of the last window wrapping onto the outs of window 0). Each transaction on the
// slave side is a read, write, save or restore and returns exactly one result on the
// master side: read data (zero unless a read), a trap flag for window overflow or
// underflow, and the window pointer after the action. The transaction is captured at
// the accepting edge, then the single-port store is accessed with its registered read,
// then the result register is loaded. A new transaction is accepted only once the
// previous one has loaded its result; a stalled result holds the pipeline in its load
// step. Store contents are undefined until written.
module windowed_register_file
    import wrf_pkg::*;
#(
    parameter int WINDOWS = WINDOWS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [4:0] reg_number, [36:5] write_data
    input  logic [S_TUSER_W-1:0] s_tuser,   // [1:0] action
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [31:0] read_data, [32] window_trap,
                                            // [37:33] window_pointer
);

    ctrl_cmd_t         cmd;
    logic [DATA_W-1:0] read_data;
    logic              window_trap;
    logic [WP_W-1:0]   window_pointer;

    wrf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    wrf_datapath #(
        .WINDOWS (WINDOWS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .action         (action_t'(s_tuser[1:0])),
        .reg_number     (s_tdata[NUM_W-1:0]),
        .write_data     (s_tdata[NUM_W +: DATA_W]),
        .read_data      (read_data),
        .window_trap    (window_trap),
        .window_pointer (window_pointer)
    );

    assign m_tdata = {(M_TDATA_W - DATA_W - 1 - WP_W)'(0), window_pointer, window_trap, read_data};

endmodule

[rtl/wrf_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the windowed register file, bound to the top level.
// Depends on wrf_pkg and the port list of windowed_register_file.
module wrf_checker
    import wrf_pkg::*;
#(
    parameter int WINDOWS = WINDOWS_DEF
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    localparam logic [WP_W-1:0] LAST_WIN = WP_W'(WINDOWS - 1);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_trap_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[32] |-> m_tdata[31:0] == '0)
        else $error("trap result carries read data");

    a_trap_pointer: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[32] |-> m_tdata[37:33] == '0 || m_tdata[37:33] == LAST_WIN)
        else $error("trap with pointer not at an end window");

    a_pointer_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[37:33] <= LAST_WIN)
        else $error("window pointer out of range");

endmodule

bind windowed_register_file wrf_checker #(
    .WINDOWS (WINDOWS)
) u_wrf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[sim/windowed_register_file_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for windowed_register_file: directed and random register accesses
// and window moves, with a shadow register file that predicts every result.
// Depends on wrf_pkg and the windowed_register_file RTL.
module windowed_register_file_tb;
    import wrf_pkg::*;

    localparam int STORE_DEPTH = GLOBAL_REGS + WINDOWS_DEF * WIN_SPAN;
    localparam int RANDOM_ACCESSES = 1230;

    typedef struct {
        action_t           act;
        logic [NUM_W-1:0]  num;
        logic [DATA_W-1:0] data;
        bit                drain_first;
    } access_t;

    typedef struct {
        logic [DATA_W-1:0] read_data;
        logic              trap;
        logic [WP_W-1:0]   wp;
    } reply_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;   // [4:0] reg_number, [36:5] write_data
    logic [S_TUSER_W-1:0] s_tuser = '0;   // [1:0] action
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;        // [31:0] read_data, [32] window_trap,
                                          // [37:33] window_pointer

    access_t access_q[$];
    reply_t  reply_q[$];

    logic [DATA_W-1:0] shadow_regs [STORE_DEPTH];
    logic [WP_W-1:0]   shadow_wp;

    logic [WP_W-1:0]   plan_wp;
    bit                plan_written [STORE_DEPTH];

    int unsigned err_cnt = 0;
    int unsigned accepted_cnt = 0;
    int unsigned send_gap = 0;
    int unsigned send_calm = 0;
    int unsigned recv_wait = 0;
    int unsigned recv_calm = 0;
    logic        hold_results = 1'b0;

    windowed_register_file #(
        .WINDOWS(WINDOWS_DEF)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #1 aclk = ~aclk;

    function automatic int unsigned flat_slot(input logic [WP_W-1:0] wp,
                                              input logic [NUM_W-1:0] num);
        int unsigned idx;
        if (num < GLOBAL_REGS) return 32'(num);
        if (wp == WINDOWS_DEF - 1 && num >= GLOBAL_REGS + WIN_SPAN)
            idx = num - WIN_SPAN;
        else
            idx = wp * WIN_SPAN + num;
        return idx % STORE_DEPTH;
    endfunction

    function automatic logic [WP_W-1:0] step_window(input action_t act,
                                                    input logic [WP_W-1:0] wp,
                                                    output logic trap);
        trap = 1'b0;
        case (act)
            ACT_SAVE: begin
                if (wp >= WINDOWS_DEF - 1) begin
                    trap = 1'b1;
                    return '0;
                end
                return wp + 1'b1;
            end
            ACT_RESTORE: begin
                if (wp == 0 || wp >= WINDOWS_DEF) begin
                    trap = 1'b1;
                    return WP_W'(WINDOWS_DEF - 1);
                end
                return wp - 1'b1;
            end
            default: return wp;
        endcase
    endfunction

    function automatic int unsigned pick_pause(inout int unsigned calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 6);
    endfunction

    // Track the window and written slots at plan time so reads only hit defined entries.
    task automatic plan_access(input action_t act, input logic [NUM_W-1:0] num,
                               input logic [DATA_W-1:0] data, input bit drain_first = 1'b0);
        access_t a;
        logic    trap;
        a.act = act;
        a.num = num;
        a.data = data;
        a.drain_first = drain_first;
        access_q.push_back(a);
        if (act == ACT_WRITE && num != REG_ZERO)
            plan_written[flat_slot(plan_wp, num)] = 1'b1;
        plan_wp = step_window(act, plan_wp, trap);
    endtask

    function automatic logic [NUM_W-1:0] pick_readable();
        logic [NUM_W-1:0] cand[$];
        for (int n = 1; n < 32; n++)
            if (plan_written[flat_slot(plan_wp, NUM_W'(n))]) cand.push_back(NUM_W'(n));
        if (cand.size() == 0 || $urandom_range(0, 30) == 0) return REG_ZERO;
        return cand[$urandom_range(0, cand.size() - 1)];
    endfunction

    task automatic predict_reply(input access_t a);
        reply_t r;
        r.read_data = '0;
        if (a.act == ACT_READ && a.num != REG_ZERO)
            r.read_data = shadow_regs[flat_slot(shadow_wp, a.num)];
        if (a.act == ACT_WRITE && a.num != REG_ZERO)
            shadow_regs[flat_slot(shadow_wp, a.num)] = a.data;
        shadow_wp = step_window(a.act, shadow_wp, r.trap);
        r.wp = shadow_wp;
        reply_q.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] exp_v,
                                   input logic [DATA_W-1:0] got_v);
        err_cnt++;
        $display("MISMATCH at %0t: %s expected 0x%08h got 0x%08h", $realtime, what, exp_v,
                 got_v);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_reply('{act: action_t'(s_tuser), num: s_tdata[4:0],
                                data: s_tdata[36:5], drain_first: 1'b0});
                accepted_cnt++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (access_q.size() > 0 &&
                             !(access_q[0].drain_first && reply_q.size() > 0)) begin
                    s_tdata  <= {3'b000, access_q[0].data, access_q[0].num};
                    s_tuser  <= access_q[0].act;
                    s_tvalid <= 1'b1;
                    void'(access_q.pop_front());
                    send_gap = pick_pause(send_calm);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (reply_q.size() == 0) begin
                    report_mismatch("unexpected result transaction", '0, m_tdata[31:0]);
                end else begin
                    if (m_tdata[31:0] !== reply_q[0].read_data)
                        report_mismatch("read_data", reply_q[0].read_data, m_tdata[31:0]);
                    if (m_tdata[32] !== reply_q[0].trap)
                        report_mismatch("window_trap", DATA_W'(reply_q[0].trap),
                                        DATA_W'(m_tdata[32]));
                    if (m_tdata[37:33] !== reply_q[0].wp)
                        report_mismatch("window_pointer", DATA_W'(reply_q[0].wp),
                                        DATA_W'(m_tdata[37:33]));
                    void'(reply_q.pop_front());
                end
                recv_wait = pick_pause(recv_calm);
            end else if (recv_wait > 0) begin
                recv_wait--;
            end
            m_tready <= !hold_results && recv_wait == 0;
        end
    end

    // Stall the result side for a long stretch while the sender keeps offering.
    initial begin
        while (accepted_cnt < 500) @(posedge aclk);
        hold_results <= 1'b1;
        repeat (400) @(posedge aclk);
        hold_results <= 1'b0;
    end

    initial begin
        #1_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int unsigned planned;
        int unsigned r;
        int unsigned run;
        plan_wp = '0;
        shadow_wp = '0;
        for (int i = 0; i < STORE_DEPTH; i++) begin
            plan_written[i] = 1'b0;
            shadow_regs[i] = '0;
        end

        plan_access(ACT_WRITE, 5'd0, 32'hFFFF_FFFF);
        plan_access(ACT_READ, 5'd0, 32'h0);
        plan_access(ACT_WRITE, 5'd1, 32'hFFFF_FFFF);
        plan_access(ACT_WRITE, 5'd7, 32'h0000_0000);
        plan_access(ACT_WRITE, 5'd8, 32'hA5A5_5A5A);
        plan_access(ACT_WRITE, 5'd31, 32'h1234_5678);
        plan_access(ACT_READ, 5'd1, 32'h0);
        plan_access(ACT_READ, 5'd7, 32'h0);
        plan_access(ACT_READ, 5'd31, 32'h0);
        plan_access(ACT_SAVE, 5'd0, 32'h0);
        plan_access(ACT_READ, 5'd15, 32'h0);
        plan_access(ACT_RESTORE, 5'd0, 32'h0);
        plan_access(ACT_RESTORE, 5'd0, 32'h0);
        plan_access(ACT_READ, 5'd24, 32'h0);
        plan_access(ACT_WRITE, 5'd31, 32'h8000_0001);
        plan_access(ACT_WRITE, 5'd23, 32'h7FFF_FFFE);
        plan_access(ACT_READ, 5'd23, 32'h0);
        plan_access(ACT_SAVE, 5'd0, 32'h0);
        plan_access(ACT_READ, 5'd15, 32'h0);
        plan_access(ACT_READ, 5'd8, 32'h0, 1'b1);

        planned = 0;
        while (planned < RANDOM_ACCESSES) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 49) == 0) begin
                run = $urandom_range(WINDOWS_DEF, WINDOWS_DEF + 3);
                for (int k = 0; k < run; k++)
                    plan_access(r[0] ? ACT_SAVE : ACT_RESTORE, NUM_W'($urandom),
                                $urandom);
                planned += run;
            end else begin
                if (r < 40)
                    plan_access(ACT_READ, pick_readable(), $urandom);
                else if (r < 75)
                    plan_access(ACT_WRITE, NUM_W'($urandom_range(0, 31)), $urandom,
                                planned == 800);
                else if (r < 88)
                    plan_access(ACT_SAVE, NUM_W'($urandom), $urandom);
                else
                    plan_access(ACT_RESTORE, NUM_W'($urandom), $urandom);
                planned++;
            end
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (access_q.size() > 0 || s_tvalid) @(posedge aclk);
        while (reply_q.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (reply_q.size() > 0)
            report_mismatch("results still outstanding", DATA_W'(reply_q.size()), '0);
        if (err_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
